>>> hw/rtl/poi_pkg.sv
`timescale 1ns / 1ps
package poi_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int STAGE_RUN     = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam logic [4:0] STAGE_LAST = 5'(STAGE_RUN - 1);

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [1:0] OP_INTEGRATE = 2'd0;
  localparam logic [1:0] OP_ZERO      = 2'd1;
  localparam logic [1:0] OP_SET       = 2'd2;

  typedef struct packed {
    logic start;
    logic b_signed;
  } smul_ctl_t;

  function automatic logic [31:0] poi_atan(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A2F;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028B;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000A2;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000028;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000002;
      5'd29:   r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/poi_ifs.sv
`timescale 1ns / 1ps
interface poi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [31:0]        time_stamp;
  logic signed [23:0] linear_velocity;
  logic signed [31:0] angular_rate;
  logic [31:0]        sequence_req;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic [31:0]        new_heading;

  modport source (output valid, operation, time_stamp, linear_velocity, angular_rate,
                  sequence_req, new_x, new_y, new_heading, input ready);
  modport sink (input valid, operation, time_stamp, linear_velocity, angular_rate,
                sequence_req, new_x, new_y, new_heading, output ready);
endinterface

interface poi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [31:0]        pose_heading;
  logic [31:0]        sequence_out;
  logic               method_used;

  modport source (output valid, pose_x, pose_y, pose_heading, sequence_out, method_used,
                  input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, sequence_out, method_used,
                output ready);
endinterface

>>> hw/rtl/planar_odometry_integrator.sv
`timescale 1ns / 1ps
// An integrate transaction runs a bit-serial multiply for the turn, an iterative
// CORDIC pass, one stage a cycle, then two bit-serial multiplies for the step, and
// waits for a free output register. No other transaction is accepted meanwhile.
// Reset and set transactions give no result.
// Reset (rst_n, synchronous, active low) zeroes pose, last stamp and method; no sweep.
module planar_odometry_integrator (
  input  logic      clk,
  input  logic      rst_n,
  poi_in_if.sink    in_ch,
  poi_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_data
);
  import poi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TURN,
    ST_ROT,
    ST_VEL,
    ST_STEP,
    ST_EMIT
  } state_t;

  state_t state_r;

  logic               method_r;
  logic [31:0]        pos_x_r;
  logic [31:0]        pos_y_r;
  logic [31:0]        head_r;
  logic [31:0]        last_r;
  logic [31:0]        dt_r;
  logic signed [23:0] v_r;
  logic [31:0]        turn_r;
  logic [31:0]        seq_r;
  logic               mth_r;

  logic               out_valid_r;
  logic [31:0]        ox_r;
  logic [31:0]        oy_r;
  logic [31:0]        oh_r;
  logic [31:0]        oseq_r;
  logic               om_r;

  logic               acc;
  logic [31:0]        dt_in;
  smul_ctl_t          m0_ctl;
  smul_ctl_t          m1_ctl;
  logic [31:0]        m0_a;
  logic [31:0]        m0_b;
  logic [31:0]        m1_a;
  logic               m0_done;
  logic               m1_done;
  logic [63:0]        p0;
  logic [63:0]        p1;
  logic               cor_start;
  logic [31:0]        cor_angle;
  logic               cor_done;
  logic signed [31:0] cos_q30;
  logic signed [31:0] sin_q30;
  logic [31:0]        v_ext;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign dt_in       = in_ch.time_stamp - last_r;
  assign v_ext       = {{8{v_r[23]}}, v_r};

  assign cor_start = (state_r == ST_TURN) && m0_done;
  assign cor_angle = head_r + (mth_r ? p0[44:13] : 32'd0);

  always_comb begin
    m0_ctl.start    = 1'b0;
    m1_ctl.start    = 1'b0;
    m0_ctl.b_signed = (state_r == ST_ROT);
    m1_ctl.b_signed = (state_r == ST_ROT);
    m0_a            = '0;
    m0_b            = '0;
    m1_a            = '0;
    case (state_r)
      ST_IDLE: begin
        m0_ctl.start = acc && (in_ch.operation == OP_INTEGRATE);
        m0_a         = in_ch.angular_rate;
        m0_b         = dt_in;
      end
      ST_ROT: begin
        m0_ctl.start = cor_done;
        m1_ctl.start = cor_done;
        m0_a         = cos_q30;
        m1_a         = sin_q30;
        m0_b         = v_ext;
      end
      ST_VEL: begin
        m0_ctl.start = m0_done;
        m1_ctl.start = m0_done;
        m0_a         = p0[61:30];
        m1_a         = p1[61:30];
        m0_b         = dt_r;
      end
      default: begin
        m0_b = '0;
      end
    endcase
  end

  poi_smul u_mul0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (m0_ctl),
    .a       (m0_a),
    .b       (m0_b),
    .done    (m0_done),
    .product (p0)
  );

  poi_smul u_mul1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (m1_ctl),
    .a       (m1_a),
    .b       (m0_b),
    .done    (m1_done),
    .product (p1)
  );

  poi_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      method_r    <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      head_r      <= '0;
      last_r      <= '0;
    end else begin
      if (cfg_we) begin
        method_r <= cfg_data;
      end
      if (out_valid_r && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            case (in_ch.operation)
              OP_INTEGRATE: begin
                dt_r    <= dt_in;
                last_r  <= in_ch.time_stamp;
                v_r     <= in_ch.linear_velocity;
                seq_r   <= in_ch.sequence_req;
                mth_r   <= method_r;
                state_r <= ST_TURN;
              end
              OP_ZERO: begin
                pos_x_r <= '0;
                pos_y_r <= '0;
                head_r  <= '0;
              end
              OP_SET: begin
                pos_x_r <= in_ch.new_x;
                pos_y_r <= in_ch.new_y;
                head_r  <= in_ch.new_heading;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_TURN: begin
          if (m0_done) begin
            turn_r  <= p0[43:12];
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (cor_done) begin
            state_r <= ST_VEL;
          end
        end
        ST_VEL: begin
          if (m0_done) begin
            state_r <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (m0_done) begin
            pos_x_r <= pos_x_r + p0[51:20];
            pos_y_r <= pos_y_r + p1[51:20];
            head_r  <= head_r + turn_r;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            ox_r        <= pos_x_r;
            oy_r        <= pos_y_r;
            oh_r        <= head_r;
            oseq_r      <= seq_r;
            om_r        <= mth_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pose_x       = ox_r;
  assign out_ch.pose_y       = oy_r;
  assign out_ch.pose_heading = oh_r;
  assign out_ch.sequence_out = oseq_r;
  assign out_ch.method_used  = om_r;

  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VEL || state_r == ST_STEP) |-> (m0_done == m1_done))
    else $error("multipliers out of step");

  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == ST_ROT))
    else $error("rotation finished outside its state");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result raised without a finished update");
endmodule

>>> hw/rtl/poi_smul.sv
`timescale 1ns / 1ps
module poi_smul (
  input  logic              clk,
  input  logic              rst_n,
  input  poi_pkg::smul_ctl_t ctl,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [63:0]       product
);
  import poi_pkg::*;

  logic [31:0] hi_r;
  logic [31:0] lo_r;
  logic [31:0] a_r;
  logic [4:0]  cnt_r;
  logic        bsg_r;
  logic        busy_r;
  logic        done_r;

  logic [32:0] hi_e;
  logic [32:0] a_e;
  logic [32:0] sum;
  logic        last;

  assign hi_e = {hi_r[31], hi_r};
  assign a_e  = {a_r[31], a_r};
  assign last = (cnt_r == 5'd31);

  // subtract on the sign bit of a signed multiplier
  always_comb begin
    if (!lo_r[0]) begin
      sum = hi_e;
    end else if (bsg_r && last) begin
      sum = hi_e - a_e;
    end else begin
      sum = hi_e + a_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last && !ctl.start;
      if (ctl.start) begin
        hi_r   <= '0;
        lo_r   <= b;
        a_r    <= a;
        bsg_r  <= ctl.b_signed;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        hi_r  <= sum[32:1];
        lo_r  <= {sum[0], lo_r[31:1]};
        cnt_r <= cnt_r + 5'd1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};
endmodule

>>> hw/rtl/poi_cordic.sv
`timescale 1ns / 1ps
module poi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);
  import poi_pkg::*;

  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic signed [33:0] z_r;
  logic [4:0]         i_r;
  logic               flip_r;
  logic               busy_r;
  logic               done_r;

  logic               fold;
  logic [31:0]        ang_f;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [33:0] at;

  // fold into the right half plane
  assign fold  = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
  assign ang_f = {angle[31] ^ fold, angle[30:0]};
  assign dx    = y_r >>> i_r;
  assign dy    = x_r >>> i_r;
  assign at    = $signed({2'b00, poi_atan(i_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= busy_r && (i_r == STAGE_LAST) && !start;
      if (start) begin
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= {{2{ang_f[31]}}, ang_f};
        flip_r <= fold;
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        i_r <= i_r + 5'd1;
        if (i_r == STAGE_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done    = done_r;
  assign cos_q30 = flip_r ? -x_r : x_r;
  assign sin_q30 = flip_r ? -y_r : y_r;
endmodule
